@@ sv/wal_frame_hash_lookup_macros.svh @@
// Assertion macros for the frame hash lookup block.
// Define ASSERT_OFF to compile every check out.
`ifndef WAL_FRAME_HASH_LOOKUP_MACROS_SVH
`define WAL_FRAME_HASH_LOOKUP_MACROS_SVH

`ifndef ASSERT_OFF
`define WFHL_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define WFHL_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`else
`define WFHL_ASSERT(lbl, clk, rstn, prop, msg)
`define WFHL_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

@@ sv/wfhl_pkg.sv @@
package wfhl_pkg;

	localparam int KIND_W    = 2;
	localparam int TIDX_W    = 2;
	localparam int POS_W     = 13;
	localparam int OFF_W     = 13;
	localparam int PAGE_W    = 32;
	localparam int FRAME_W   = 14;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 14;

	localparam int HASH_MULT   = 383;
	localparam int HASH_MULT_W = 9;

	typedef enum logic [KIND_W-1:0] {
		KIND_SLOT   = 2'd0,
		KIND_PAGE   = 2'd1,
		KIND_LOOKUP = 2'd2
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MAX_FRAME  = 2'd0,
		REG_MIN_FRAME  = 2'd1,
		REG_BYPASS_LOG = 2'd2
	} cfg_reg_t;

	typedef enum logic [8:0] {
		S_CLEAR = 9'b000000001,
		S_IDLE  = 9'b000000010,
		S_DIVHI = 9'b000000100,
		S_DIVLO = 9'b000001000,
		S_TBL   = 9'b000010000,
		S_SRD   = 9'b000100000,
		S_SCHK  = 9'b001000000,
		S_PCHK  = 9'b010000000,
		S_FIN   = 9'b100000000
	} state_t;

endpackage

@@ sv/wfhl_tdiv.sv @@
module wfhl_tdiv
	import wfhl_pkg::*;
#(
	parameter int PAGES_PER_TABLE   = 4096,
	parameter int FIRST_TABLE_PAGES = 4062,
	parameter int TN_W              = 3
) (
	input  logic [FRAME_W-1:0] frame,
	output logic [TN_W-1:0]    tnum
);

	// table = (frame + PAGES - FIRST - 1) / PAGES, by exact reciprocal multiply;
	// a negative dividend saturates (wraps to a huge table in unsigned terms)
	localparam int XN = $clog2((1 << FRAME_W) + PAGES_PER_TABLE + FIRST_TABLE_PAGES + 1);
	localparam int SH = XN + $clog2(PAGES_PER_TABLE);
	localparam longint unsigned RM =
		((64'd1 << SH) + 64'(PAGES_PER_TABLE) - 64'd1) / 64'(PAGES_PER_TABLE);
	localparam int MW = $clog2(RM + 1);

	logic signed [XN:0]   x_w;
	logic [XN+MW-1:0]     prod_w;

	assign x_w    = $signed({1'b0, XN'(frame)})
		+ (XN+1)'(PAGES_PER_TABLE - FIRST_TABLE_PAGES - 1);
	assign prod_w = (XN+MW)'(x_w[XN-1:0]) * (XN+MW)'(RM);
	assign tnum   = x_w[XN] ? '1 : TN_W'(prod_w >> SH);

endmodule

@@ sv/wfhl_slot_mem.sv @@
module wfhl_slot_mem
	import wfhl_pkg::*;
#(
	parameter int DEPTH = 32768,
	parameter int AW    = 15
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [OFF_W-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [OFF_W-1:0] rdata,
	output logic             clearing
);

	logic [OFF_W-1:0] mem [DEPTH];
	logic [AW-1:0]    clr_q;
	logic             clearing_q;
	logic             mem_we;
	logic [AW-1:0]    mem_addr;
	logic [OFF_W-1:0] mem_wdata;

	assign clearing  = clearing_q;
	assign mem_we    = clearing_q || we;
	assign mem_addr  = clearing_q ? clr_q : waddr;
	assign mem_wdata = clearing_q ? '0 : wdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= '0;
			clearing_q <= 1'b1;
		end else if (clearing_q) begin
			clr_q <= clr_q + AW'(1);
			if (clr_q == AW'(DEPTH - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ sv/wfhl_page_mem.sv @@
module wfhl_page_mem
	import wfhl_pkg::*;
#(
	parameter int DEPTH = 16384,
	parameter int AW    = 14
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  logic [PAGE_W-1:0] wdata,
	input  logic [AW-1:0]     raddr,
	output logic [PAGE_W-1:0] rdata
);

	logic [PAGE_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ sv/wal_frame_hash_lookup.sv @@
// Writes, unused kinds and empty or bypassed lookups go from idle straight to the finish state.
// Lookup: top and bottom table divides, then a table step per table (out-of-bank clamp
// and window end included), a slot read and check per probed slot and a page compare
// per candidate. One item at a time, stall high while busy (slot and page memories, one
// read each per cycle). Reset (async, active low) zeroes the control and configuration
// registers, then clears the slot store one entry per cycle over every entry, req_stall high.
`include "wal_frame_hash_lookup_macros.svh"

module wal_frame_hash_lookup
	import wfhl_pkg::*;
#(
	parameter int TABLES            = 4,
	parameter int PAGES_PER_TABLE   = 4096,
	parameter int SLOTS_PER_TABLE   = 8192,
	parameter int FIRST_TABLE_PAGES = 4062
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  logic [KIND_W-1:0]    kind,
	input  logic [TIDX_W-1:0]    table_index,
	input  logic [POS_W-1:0]     position,
	input  logic [OFF_W-1:0]     slot_value,
	input  logic [PAGE_W-1:0]    page_value,
	input  logic [PAGE_W-1:0]    lookup_page,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output logic [FRAME_W-1:0]   found_frame,
	output logic                 status
);

	localparam int SLOT_W = $clog2(SLOTS_PER_TABLE);
	localparam int SA_W   = $clog2(TABLES * SLOTS_PER_TABLE);
	localparam int PA_W   = $clog2(TABLES * PAGES_PER_TABLE);
	localparam int REM_W  = SLOT_W + 1;
	localparam int QMAX   = ((1 << FRAME_W) + PAGES_PER_TABLE) / PAGES_PER_TABLE;
	localparam int TCAP   = (QMAX > TABLES) ? QMAX : TABLES;
	localparam int TN_W   = $clog2(TCAP + 2);
	localparam int ZF_W   = $clog2(FIRST_TABLE_PAGES + TABLES * PAGES_PER_TABLE + 1);
	localparam int FR_W   = ((ZF_W > FRAME_W) ? ZF_W : FRAME_W) + 1;

	state_t              state_q;
	logic [FRAME_W-1:0]  max_q;
	logic [FRAME_W-1:0]  min_q;
	logic                bypass_q;
	logic                rsp_valid_q;
	logic [FRAME_W-1:0]  found_q;
	logic                status_q;

	logic [TN_W-1:0]     t_q;
	logic [TN_W-1:0]     lo_q;
	logic [SLOT_W-1:0]   key0_q;
	logic [SLOT_W-1:0]   key_q;
	logic [REM_W-1:0]    rem_q;
	logic [PA_W-1:0]     pbase_q;
	logic [PAGE_W-1:0]   page_q;
	logic [FRAME_W-1:0]  hit_q;
	logic [FRAME_W-1:0]  frame_q;
	logic                corrupt_q;

	logic                accept;
	logic                clearing;
	logic [FRAME_W-1:0]  div_frame;
	logic [TN_W-1:0]     div_q;
	logic [SLOT_W+HASH_MULT_W-1:0] hash_w;
	logic [SLOT_W-1:0]   key_w;
	logic [ZF_W-1:0]     zf_w;
	logic [OFF_W-1:0]    slot_rdata;
	logic [PAGE_W-1:0]   page_rdata;
	logic [FR_W-1:0]     frame_w;
	logic                cand_w;
	logic                out_free;
	logic                slot_we;
	logic [SA_W-1:0]     slot_waddr;
	logic [SA_W-1:0]     slot_raddr;
	logic                page_we;
	logic [PA_W-1:0]     page_waddr;
	logic [PA_W-1:0]     page_raddr;

	assign req_stall   = (state_q != S_IDLE);
	assign accept      = req_valid && !req_stall;
	assign rsp_valid   = rsp_valid_q;
	assign found_frame = found_q;
	assign status      = status_q;
	assign out_free    = !rsp_valid_q || !rsp_stall;

	assign hash_w = (SLOT_W+HASH_MULT_W)'(lookup_page[SLOT_W-1:0])
		* (SLOT_W+HASH_MULT_W)'(HASH_MULT);
	assign key_w  = hash_w[SLOT_W-1:0];

	assign div_frame = (state_q == S_DIVHI) ? max_q : min_q;

	wfhl_tdiv #(
		.PAGES_PER_TABLE   (PAGES_PER_TABLE),
		.FIRST_TABLE_PAGES (FIRST_TABLE_PAGES),
		.TN_W              (TN_W)
	) u_tdiv (
		.frame (div_frame),
		.tnum  (div_q)
	);

	assign slot_we    = accept && (kind == KIND_SLOT)
		&& (32'(table_index) < 32'(TABLES)) && (32'(position) < 32'(SLOTS_PER_TABLE));
	assign slot_waddr = (SA_W'(table_index) << SLOT_W) | SA_W'(position);
	assign slot_raddr = (SA_W'(t_q) << SLOT_W) | SA_W'(key_q);

	assign page_we    = accept && (kind == KIND_PAGE)
		&& (32'(table_index) < 32'(TABLES)) && (32'(position) < 32'(PAGES_PER_TABLE));
	assign page_waddr = PA_W'(table_index) * PA_W'(PAGES_PER_TABLE) + PA_W'(position);
	assign page_raddr = pbase_q + PA_W'(slot_rdata) - PA_W'(1);

	wfhl_slot_mem #(
		.DEPTH (TABLES * SLOTS_PER_TABLE),
		.AW    (SA_W)
	) u_slot_mem (
		.clk      (clk),
		.arst_n   (arst_n),
		.we       (slot_we),
		.waddr    (slot_waddr),
		.wdata    (slot_value),
		.raddr    (slot_raddr),
		.rdata    (slot_rdata),
		.clearing (clearing)
	);

	wfhl_page_mem #(
		.DEPTH (TABLES * PAGES_PER_TABLE),
		.AW    (PA_W)
	) u_page_mem (
		.clk   (clk),
		.we    (page_we),
		.waddr (page_waddr),
		.wdata (page_value),
		.raddr (page_raddr),
		.rdata (page_rdata)
	);

	// frame number of slot offset zero in the current table
	assign zf_w    = (t_q == '0) ? '0
		: ZF_W'(pbase_q) + ZF_W'(FIRST_TABLE_PAGES) - ZF_W'(PAGES_PER_TABLE);
	assign frame_w = FR_W'(slot_rdata) + FR_W'(zf_w);
	assign cand_w  = (frame_w <= FR_W'(max_q)) && (frame_w >= FR_W'(min_q))
		&& (32'(slot_rdata) <= 32'(PAGES_PER_TABLE));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			rsp_valid_q <= 1'b0;
			max_q       <= '0;
			min_q       <= '0;
			bypass_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_MAX_FRAME:  max_q    <= cfg_data;
					REG_MIN_FRAME:  min_q    <= cfg_data;
					REG_BYPASS_LOG: bypass_q <= cfg_data[0];
					default: ;
				endcase
			end
			if (rsp_valid_q && !rsp_stall && state_q != S_FIN) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					if (!clearing) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						if (kind == KIND_LOOKUP && max_q != '0 && !bypass_q) begin
							state_q <= S_DIVHI;
						end else begin
							state_q <= S_FIN;
						end
					end
				end
				S_DIVHI: state_q <= S_DIVLO;
				S_DIVLO: state_q <= S_TBL;
				S_TBL: begin
					if (t_q < lo_q) begin
						state_q <= S_FIN;
					end else if (t_q < TN_W'(TABLES)) begin
						state_q <= S_SRD;
					end
				end
				S_SRD: state_q <= S_SCHK;
				S_SCHK: begin
					if (slot_rdata == '0) begin
						state_q <= (hit_q != '0 || t_q == '0) ? S_FIN : S_TBL;
					end else if (cand_w) begin
						state_q <= S_PCHK;
					end else begin
						state_q <= (rem_q == '0) ? S_FIN : S_SRD;
					end
				end
				S_PCHK: state_q <= (rem_q == '0) ? S_FIN : S_SRD;
				S_FIN: begin
					if (out_free) begin
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_CLEAR;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					hit_q     <= '0;
					corrupt_q <= 1'b0;
					page_q    <= lookup_page;
					key0_q    <= key_w;
				end
			end
			S_DIVHI: t_q  <= div_q;
			S_DIVLO: lo_q <= div_q;
			S_TBL: begin
				if (t_q >= lo_q) begin
					if (t_q >= TN_W'(TABLES)) begin
						// tables past the bank hold nothing
						t_q <= TN_W'(TABLES - 1);
					end else begin
						pbase_q <= PA_W'(t_q) * PA_W'(PAGES_PER_TABLE);
						key_q   <= key0_q;
						rem_q   <= REM_W'(SLOTS_PER_TABLE);
					end
				end
			end
			S_SCHK: begin
				if (slot_rdata == '0) begin
					t_q <= t_q - TN_W'(1);
				end else if (cand_w) begin
					frame_q <= FRAME_W'(frame_w);
				end else if (rem_q == '0) begin
					corrupt_q <= 1'b1;
				end else begin
					rem_q <= rem_q - REM_W'(1);
					key_q <= key_q + SLOT_W'(1);
				end
			end
			S_PCHK: begin
				if (page_rdata == page_q) begin
					hit_q <= frame_q;
				end
				if (rem_q == '0) begin
					corrupt_q <= 1'b1;
				end else begin
					rem_q <= rem_q - REM_W'(1);
					key_q <= key_q + SLOT_W'(1);
				end
			end
			S_FIN: begin
				if (out_free) begin
					found_q  <= corrupt_q ? '0 : hit_q;
					status_q <= corrupt_q;
				end
			end
			default: ;
		endcase
	end

	`WFHL_ASSERT_IMPLIES(a_no_xfer_while_clearing, clk, arst_n, clearing, req_stall, "transfer during slot clear")
	`WFHL_ASSERT_IMPLIES(a_corrupt_zero_frame, clk, arst_n, rsp_valid && status, found_frame == '0, "corrupt result with frame")
	`WFHL_ASSERT_IMPLIES(a_frame_in_window, clk, arst_n, rsp_valid, found_frame <= max_q, "found frame above max_frame")
	`WFHL_ASSERT_IMPLIES(a_slot_read_order, clk, arst_n, state_q == S_SCHK, $past(state_q) == S_SRD, "slot check without read")
	`WFHL_ASSERT(a_rem_bound, clk, arst_n, (state_q != S_SRD && state_q != S_SCHK && state_q != S_PCHK) || rem_q <= REM_W'(SLOTS_PER_TABLE), "probe budget out of range")

endmodule

@@ tb/wal_frame_hash_lookup_test.sv @@
`timescale 1ns / 100ps

module wal_frame_hash_lookup_test;
	import wfhl_pkg::*;

	localparam int N_TABLES    = 4;
	localparam int TABLE_PAGES = 4096;
	localparam int TABLE_SLOTS = 8192;
	localparam int FIRST_PAGES = 4062;
	localparam int IDLE_LIMIT  = 200000;

	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

	typedef struct {
		logic [KIND_W-1:0] kind;
		logic [TIDX_W-1:0] tbl;
		logic [POS_W-1:0]  pos;
		logic [OFF_W-1:0]  offset;
		logic [PAGE_W-1:0] page;
		logic [PAGE_W-1:0] sought;
	} wal_req_t;

	typedef struct {
		logic [FRAME_W-1:0] frame;
		logic               corrupt;
	} frame_answer_t;

	logic                 clk;
	logic                 arst_n      = 1'b0;
	logic                 cfg_we      = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index   = '0;
	logic [CFG_W-1:0]     cfg_data    = '0;
	logic                 req_valid   = 1'b0;
	logic                 req_stall;
	logic [KIND_W-1:0]    kind        = '0;
	logic [TIDX_W-1:0]    table_index = '0;
	logic [POS_W-1:0]     position    = '0;
	logic [OFF_W-1:0]     slot_value  = '0;
	logic [PAGE_W-1:0]    page_value  = '0;
	logic [PAGE_W-1:0]    lookup_page = '0;
	logic                 rsp_valid;
	logic                 rsp_stall   = 1'b0;
	logic [FRAME_W-1:0]   found_frame;
	logic                 status;

	// mirror of the block state
	logic [OFF_W-1:0]   slot_mirror [N_TABLES][TABLE_SLOTS];
	logic [PAGE_W-1:0]  page_mirror [N_TABLES][TABLE_PAGES];
	bit                 page_set    [N_TABLES][TABLE_PAGES];
	logic [FRAME_W-1:0] last_frame_cfg = '0;
	logic [FRAME_W-1:0] low_frame_cfg  = '0;
	logic               bypass_cfg     = 1'b0;

	wal_req_t      pending_reqs[$];
	frame_answer_t due_answers[$];
	wal_req_t      cur_req;
	int            mismatches  = 0;
	int            burst_left  = 0;
	int            gap_left    = 0;
	int            quiet_cycles = 0;
	int unsigned   stall_tick  = 0;
	int unsigned   stall_mode  = 0;

	wal_frame_hash_lookup #(
		.TABLES(N_TABLES),
		.PAGES_PER_TABLE(TABLE_PAGES),
		.SLOTS_PER_TABLE(TABLE_SLOTS),
		.FIRST_TABLE_PAGES(FIRST_PAGES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.kind(kind),
		.table_index(table_index),
		.position(position),
		.slot_value(slot_value),
		.page_value(page_value),
		.lookup_page(lookup_page),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.found_frame(found_frame),
		.status(status)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic int unsigned hash_slot(input logic [PAGE_W-1:0] pg);
		logic [31:0] prod;
		prod = pg * 32'(HASH_MULT);
		return prod & (TABLE_SLOTS - 1);
	endfunction

	function automatic int unsigned table_of(input int unsigned frame);
		return (frame + TABLE_PAGES - FIRST_PAGES - 1) / TABLE_PAGES;
	endfunction

	// newest frame in the window that holds the page, tables walked downward
	function automatic frame_answer_t newest_frame(input logic [PAGE_W-1:0] sought);
		frame_answer_t ans;
		int unsigned   last, first_tbl, t, base, probes_left, key, off, frame, hit;
		bit            done;
		ans.frame = '0;
		ans.corrupt = 1'b0;
		hit = 0;
		done = 0;
		last = last_frame_cfg;
		if (last == 0 || bypass_cfg)
			return ans;
		first_tbl = table_of(low_frame_cfg);
		t = table_of(last);
		while (!done && t >= first_tbl) begin
			if (t < N_TABLES) begin
				base = (t == 0) ? 0 : FIRST_PAGES + (t - 1) * TABLE_PAGES;
				key = hash_slot(sought);
				probes_left = TABLE_SLOTS;
				off = slot_mirror[t][key];
				while (off != 0) begin
					frame = base + off;
					if (frame <= last && frame >= low_frame_cfg && off <= TABLE_PAGES
							&& page_mirror[t][off - 1] == sought)
						hit = frame;
					if (probes_left == 0) begin
						ans.corrupt = 1'b1;
						return ans;
					end
					probes_left--;
					key = (key + 1) & (TABLE_SLOTS - 1);
					off = slot_mirror[t][key];
				end
				if (hit != 0)
					done = 1;
			end
			if (t == 0)
				done = 1;
			else if (!done)
				t--;
		end
		ans.frame = hit[FRAME_W-1:0];
		return ans;
	endfunction

	function automatic void predict_answer(input wal_req_t r);
		frame_answer_t ans;
		ans.frame = '0;
		ans.corrupt = 1'b0;
		case (r.kind)
			KIND_SLOT: begin
				if (r.tbl < N_TABLES && r.pos < TABLE_SLOTS)
					slot_mirror[r.tbl][r.pos] = r.offset;
			end
			KIND_PAGE: begin
				if (r.tbl < N_TABLES && r.pos < TABLE_PAGES)
					page_mirror[r.tbl][r.pos] = r.page;
			end
			KIND_LOOKUP: ans = newest_frame(r.sought);
			default: ;
		endcase
		due_answers.push_back(ans);
	endfunction

	function automatic void queue_req(input logic [KIND_W-1:0] k, input int unsigned t,
			input int unsigned pos, input int unsigned off, input logic [PAGE_W-1:0] pg,
			input logic [PAGE_W-1:0] sought);
		wal_req_t r;
		r.kind = k;
		r.tbl = t[TIDX_W-1:0];
		r.pos = pos[POS_W-1:0];
		r.offset = off[OFF_W-1:0];
		r.page = pg;
		r.sought = sought;
		pending_reqs.push_back(r);
		if (k == KIND_PAGE && r.tbl < N_TABLES && r.pos < TABLE_PAGES)
			page_set[r.tbl][r.pos] = 1'b1;
	endfunction

	// mostly a small pool so that lookups hit, now and then any nonzero page
	function automatic logic [PAGE_W-1:0] pick_page();
		logic [PAGE_W-1:0] pg;
		if ($urandom_range(0, 7) != 0)
			return $urandom_range(1, 16);
		do
			pg = $urandom;
		while (pg == 0);
		return pg;
	endfunction

	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_reqs.size() != 0 || req_valid || due_answers.size() != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_window(input int unsigned last, input int unsigned low, input bit bypass);
		wait_drained();
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= REG_MAX_FRAME;
		cfg_data <= last[CFG_W-1:0];
		last_frame_cfg = last[FRAME_W-1:0];
		@(posedge clk);
		cfg_index <= REG_MIN_FRAME;
		cfg_data <= low[CFG_W-1:0];
		low_frame_cfg = low[FRAME_W-1:0];
		@(posedge clk);
		cfg_index <= REG_BYPASS_LOG;
		cfg_data <= {{(CFG_W-1){1'b0}}, bypass};
		bypass_cfg = bypass;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// request driver: bursts of transfers with random gaps
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && !req_stall)
				predict_answer(cur_req);
			if (!req_valid || !req_stall) begin
				if (gap_left > 0 || pending_reqs.size() == 0) begin
					if (gap_left > 0)
						gap_left--;
					req_valid <= 1'b0;
				end else begin
					cur_req = pending_reqs.pop_front();
					kind <= cur_req.kind;
					table_index <= cur_req.tbl;
					position <= cur_req.pos;
					slot_value <= cur_req.offset;
					page_value <= cur_req.page;
					lookup_page <= cur_req.sought;
					req_valid <= 1'b1;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(0, 24);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					end
				end
			end
		end
	end

	// response monitor and stall pattern
	always @(posedge clk) begin
		frame_answer_t want;
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				if (due_answers.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected transfer, expected none, got frame %0d status %0d",
						$time, found_frame, status);
				end else begin
					want = due_answers.pop_front();
					if (found_frame !== want.frame) begin
						mismatches++;
						$display("%0t: found_frame expected %0d, got %0d",
							$time, want.frame, found_frame);
					end
					if (status !== want.corrupt) begin
						mismatches++;
						$display("%0t: status expected %0d, got %0d",
							$time, want.corrupt, status);
					end
				end
			end
			stall_tick++;
			if (stall_tick % 64 == 0)
				stall_mode = $urandom_range(0, 3);
			case (stall_mode)
				0: rsp_stall <= 1'b0;
				1: rsp_stall <= $urandom_range(0, 1);
				2: rsp_stall <= (stall_tick % 3 == 0);
				default: rsp_stall <= ($urandom_range(0, 3) != 0);
			endcase
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == IDLE_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
			$display("end of test: mismatches");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int unsigned t, p, o, n, sel, last, low;
		bit          bypass;
		foreach (slot_mirror[i, j])
			slot_mirror[i][j] = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// empty log right after reset
		queue_req(KIND_LOOKUP, 0, 0, 0, 0, 32'h0000_0001);
		queue_req(KIND_UNUSED, 3, 8191, 8191, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		queue_req(KIND_SLOT, 0, 0, 0, 0, 0);
		queue_req(KIND_LOOKUP, 3, 8191, 8191, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		wait_drained();

		set_window(16350, 0, 0);
		queue_req(KIND_PAGE, 3, 4095, 0, 32'hFFFF_FFFF, 0);
		queue_req(KIND_PAGE, 0, 8191, 8191, 32'h0000_0005, 32'hFFFF_FFFF);
		queue_req(KIND_PAGE, 1, 0, 0, 32'h0000_0000, 0);
		queue_req(KIND_SLOT, 3, hash_slot(32'hFFFF_FFFF), 4096, 0, 0);
		queue_req(KIND_LOOKUP, 0, 0, 0, 0, 32'hFFFF_FFFF);
		queue_req(KIND_SLOT, 2, 8191, 8191, 0, 0);
		queue_req(KIND_SLOT, 2, 0, 4097, 0, 0);
		queue_req(KIND_PAGE, 1, 9, 0, 7, 0);
		queue_req(KIND_PAGE, 1, 19, 0, 7, 0);
		queue_req(KIND_PAGE, 3, 29, 0, 7, 0);
		queue_req(KIND_SLOT, 1, hash_slot(7), 10, 0, 0);
		queue_req(KIND_SLOT, 1, hash_slot(7) + 1, 20, 0, 0);
		queue_req(KIND_SLOT, 3, hash_slot(7), 30, 0, 0);
		queue_req(KIND_LOOKUP, 0, 0, 0, 0, 7);
		queue_req(KIND_LOOKUP, 0, 0, 0, 0, 1);
		queue_req(KIND_UNUSED, 1, 9, 0, 0, 7);
		queue_req(KIND_LOOKUP, 0, 0, 0, 0, 7);
		// max frame past the last table
		set_window(16383, 0, 0);
		queue_req(KIND_LOOKUP, 0, 0, 0, 0, 7);
		queue_req(KIND_LOOKUP, 0, 0, 0, 0, 32'hFFFF_FFFF);
		set_window(12283, 4063, 0);
		queue_req(KIND_LOOKUP, 0, 0, 0, 0, 7);
		// inverted window
		set_window(100, 200, 0);
		queue_req(KIND_LOOKUP, 0, 0, 0, 0, 7);
		set_window(16350, 0, 1);
		queue_req(KIND_LOOKUP, 0, 0, 0, 0, 7);

		repeat (8) begin
			case ($urandom_range(0, 7))
				0: begin
					last = 16350;
					low = 0;
				end
				1: begin
					last = ($urandom_range(0, 1) == 0) ? 0 : 16383;
					low = $urandom_range(0, 16383);
				end
				2: begin
					last = $urandom_range(1, FIRST_PAGES);
					low = 0;
				end
				3: begin
					last = $urandom_range(1, 16000);
					low = $urandom_range(last + 1, 16383);
				end
				default: begin
					last = $urandom_range(1, 16350);
					low = $urandom_range(0, last);
				end
			endcase
			bypass = ($urandom_range(0, 7) == 0);
			set_window(last, low, bypass);
			n = 0;
			while (n < 45) begin
				sel = $urandom_range(0, 19);
				if (sel < 8) begin
					t = $urandom_range(0, N_TABLES - 1);
					p = pick_page();
					o = $urandom_range(1, TABLE_PAGES);
					queue_req(KIND_PAGE, t, o - 1, $urandom, p, $urandom);
					queue_req(KIND_SLOT, t, (hash_slot(p) + $urandom_range(0, 3)) % TABLE_SLOTS,
						o, $urandom, $urandom);
					n += 2;
				end else if (sel < 15) begin
					queue_req(KIND_LOOKUP, $urandom, $urandom, $urandom, $urandom, pick_page());
					n++;
				end else if (sel < 17) begin
					t = $urandom_range(0, N_TABLES - 1);
					o = $urandom_range(0, 8191);
					// a slot offset that can be compared needs its page entry set first
					if (o != 0 && o <= TABLE_PAGES && !page_set[t][o - 1]) begin
						queue_req(KIND_PAGE, t, o - 1, $urandom, pick_page(), $urandom);
						n++;
					end
					queue_req(KIND_SLOT, t, $urandom, o, $urandom, $urandom);
					n++;
				end else if (sel < 19) begin
					queue_req(KIND_PAGE, $urandom, $urandom, $urandom, $urandom, $urandom);
					n++;
				end else begin
					queue_req(KIND_UNUSED, $urandom, $urandom, $urandom, $urandom, $urandom);
					n++;
				end
			end
		end

		set_window(12000, 0, 0);
		queue_req(KIND_LOOKUP, 0, 0, 0, 0, 7);
		queue_req(KIND_LOOKUP, 0, 0, 0, 0, pick_page());
		set_window(16350, 0, 0);
		queue_req(KIND_LOOKUP, 0, 0, 0, 0, 7);
		queue_req(KIND_LOOKUP, 0, 0, 0, 0, pick_page());
		set_window(16350, 12255, 0);
		queue_req(KIND_LOOKUP, 0, 0, 0, 0, pick_page());
		queue_req(KIND_LOOKUP, 0, 0, 0, 0, 32'hFFFF_FFFF);

		wait_drained();
		repeat (16) @(posedge clk);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
